/* rtl/crgf_pkg.sv */
// ----------------------------------------------------------------------------
// crgf_pkg: shared types and constants of the counted resource grant FIFO
// Item layouts, queue entry and status types, sequencer states and reset values.
// ----------------------------------------------------------------------------
package crgf_pkg;

  localparam int unsigned RequesterW   = 2;
  localparam int unsigned AmountW      = 8;
  localparam int unsigned WaitDepthDef = 16;

  localparam logic [AmountW-1:0] PoolReset = AmountW'(10);
  localparam logic [AmountW-1:0] CountMax  = {AmountW{1'b1}};

  typedef enum logic {
    KIND_GET = 1'b0,
    KIND_PUT = 1'b1
  } crgf_kind_e;

  typedef enum logic {
    STATUS_GRANT  = 1'b0,
    STATUS_REJECT = 1'b1
  } crgf_status_e;

  typedef struct packed {
    crgf_kind_e             kind;
    logic [RequesterW-1:0]  requester;
    logic [AmountW-1:0]     amount;
  } crgf_in_item_t;

  typedef struct packed {
    logic [RequesterW-1:0]  grant_to;
    crgf_status_e           status;
    logic                   last;
  } crgf_out_item_t;

  typedef struct packed {
    logic [RequesterW-1:0]  requester;
    logic [AmountW-1:0]     amount;
  } crgf_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } crgf_q_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GET,
    ST_PUT,
    ST_HEAD,
    ST_REL
  } crgf_state_e;

endpackage

/* rtl/counted_resource_grant_fifo.sv */
// ----------------------------------------------------------------------------
// counted_resource_grant_fifo: counting semaphore with a FIFO wait queue
// Grants, queues or rejects gets and releases waiters in order on puts.
// ----------------------------------------------------------------------------
// An item is taken only while the block is idle. A get occupies it for the
// accept and one compare of the amount against the free count. A put takes
// the accept, one saturating add, and then, if anyone waits, a read step and
// a compare step per waiter looked at (the head of the wait queue comes from
// a memory with a registered read, so each waiter is read in ST_HEAD and then
// compared in ST_REL). One 9-bit adder does every add, subtract and fit
// compare in turn. A new item can be accepted while the previous result
// still sits in the output register, but the sequencer stalls when it has a
// further result and that register is full.
// Writing the configuration register loads the free count at once.
module counted_resource_grant_fifo
  import crgf_pkg::*;
#(
  parameter int unsigned WaitDepth = WaitDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  crgf_in_item_t      in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output crgf_out_item_t     out_item_o,
  input  logic               cfg_we_i,
  input  logic [AmountW-1:0] cfg_data_i
);

  crgf_state_e state_q, state_d;

  crgf_in_item_t         item_q, item_d;
  logic [AmountW-1:0]    free_q, free_d;
  logic                  out_valid_q, out_valid_d;
  crgf_out_item_t        out_item_q, out_item_d;
  logic                  pend_valid_q, pend_valid_d;
  logic [RequesterW-1:0] pend_who_q, pend_who_d;

  logic           q_push, q_pop;
  crgf_entry_t    q_push_entry;
  crgf_entry_t    q_head;
  crgf_q_status_t q_status;

  logic               in_accept;
  logic               can_emit;
  logic               alu_sub;
  logic [AmountW-1:0] alu_b;
  logic [AmountW:0]   alu_res;
  logic               fits;
  logic               head_fits;

  crgf_wait_queue #(
    .Depth(WaitDepth)
  ) u_wait_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_entry_i(q_push_entry),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .status_o    (q_status)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign can_emit   = !out_valid_q || out_ready_i;

  // Shared adder: free + b for puts, free - b otherwise. On a subtract the
  // carry out is set exactly when b fits into the free count.
  assign alu_sub = (state_q != ST_PUT);
  assign alu_b   = (state_q == ST_REL) ? q_head.amount : item_q.amount;
  assign alu_res = {1'b0, free_q} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                   + {{AmountW{1'b0}}, alu_sub};
  assign fits      = alu_res[AmountW];
  assign head_fits = !q_status.empty && fits;

  assign q_push_entry.requester = item_q.requester;
  assign q_push_entry.amount    = item_q.amount;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = (in_item_i.kind == KIND_GET) ? ST_GET : ST_PUT;
        end
      end
      ST_GET: begin
        if (fits || q_status.full) begin
          if (can_emit) begin
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PUT: begin
        state_d = q_status.empty ? ST_IDLE : ST_HEAD;
      end
      ST_HEAD: begin
        state_d = ST_REL;
      end
      ST_REL: begin
        if (!(pend_valid_q && !can_emit)) begin
          state_d = head_fits ? ST_HEAD : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    item_d       = item_q;
    free_d       = free_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_item_d   = out_item_q;
    pend_valid_d = pend_valid_q;
    pend_who_d   = pend_who_q;
    q_push       = 1'b0;
    q_pop        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          item_d = in_item_i;
        end
      end
      ST_GET: begin
        if (fits || q_status.full) begin
          if (can_emit) begin
            if (fits) begin
              free_d = alu_res[AmountW-1:0];
            end
            out_valid_d         = 1'b1;
            out_item_d.grant_to = item_q.requester;
            out_item_d.status   = fits ? STATUS_GRANT : STATUS_REJECT;
            out_item_d.last     = 1'b1;
          end
        end else begin
          q_push = 1'b1;
        end
      end
      ST_PUT: begin
        free_d       = alu_res[AmountW] ? CountMax : alu_res[AmountW-1:0];
        pend_valid_d = 1'b0;
      end
      ST_HEAD: begin
      end
      ST_REL: begin
        // A released waiter is held back one step so that the result can
        // carry last once it is known that the next waiter does not fit.
        if (!(pend_valid_q && !can_emit)) begin
          if (pend_valid_q) begin
            out_valid_d         = 1'b1;
            out_item_d.grant_to = pend_who_q;
            out_item_d.status   = STATUS_GRANT;
            out_item_d.last     = !head_fits;
          end
          if (head_fits) begin
            free_d       = alu_res[AmountW-1:0];
            q_pop        = 1'b1;
            pend_valid_d = 1'b1;
            pend_who_d   = q_head.requester;
          end else begin
            pend_valid_d = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    if (cfg_we_i) begin
      free_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      free_q       <= PoolReset;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      free_q       <= free_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    out_item_q <= out_item_d;
    pend_who_q <= pend_who_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_valid_q)
    else $error("pending release left over in idle");

  a_reject_only_get: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_d && (!out_valid_q || out_ready_i) && out_item_d.status == STATUS_REJECT)
    |-> (state_q == ST_GET && q_status.full))
    else $error("reject issued outside a get on a full queue");

  a_pop_only_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (state_q == ST_REL && head_fits))
    else $error("wait queue popped outside a release step");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !in_ready_o)
    else $error("ready stayed high after an item was taken");

endmodule

/* rtl/crgf_wait_queue.sv */
// ----------------------------------------------------------------------------
// crgf_wait_queue: FIFO of waiting requests
// Ring memory with one write port at the tail and a registered read of the head.
// ----------------------------------------------------------------------------
module crgf_wait_queue
  import crgf_pkg::*;
#(
  parameter int unsigned Depth = WaitDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  crgf_entry_t    push_entry_i,
  input  logic           pop_i,
  output crgf_entry_t    head_o,
  output crgf_q_status_t status_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  crgf_entry_t mem_q [Depth];
  crgf_entry_t rd_q;

  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (push_i) begin
      tail_d = (tail_q == LastIdx) ? '0 : tail_q + IdxW'(1);
    end
    if (pop_i) begin
      head_d = (head_q == LastIdx) ? '0 : head_q + IdxW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // The head entry is read every cycle; after a pop the new head shows up
  // in the cycle after the pointer moves.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[tail_q] <= push_entry_i;
    end
    rd_q <= mem_q[head_q];
  end

  assign head_o         = rd_q;
  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == FullCnt);

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("wait queue pushed while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("wait queue popped while empty");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("wait queue count beyond depth");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_o.empty || status_o.full) |-> (head_q == tail_q))
    else $error("wait queue pointers disagree with count");

endmodule
